### design/ddoi_pkg.sv
`default_nettype none
package ddoi_pkg;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_TABLE_LEN = 24;
  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
  localparam logic [17:0] HEADING_COEF = 18'd174993;
  localparam logic [23:0] SCALE_RESET = 24'd88459;
  localparam logic [23:0] INV_TRACK_RESET = 24'd163840;
  localparam logic [0:0] REG_SCALE = 1'b0;
  localparam logic [0:0] REG_INV_TRACK = 1'b1;

  typedef enum logic [2:0] {
    OP_IDLE = 3'd0,
    OP_LOAD = 3'd1,
    OP_RATES = 3'd2,
    OP_ROTATE = 3'd3,
    OP_PROJECT = 3'd4,
    OP_SCALE = 3'd5,
    OP_DIVIDE = 3'd6,
    OP_COMMIT = 3'd7
  } op_t;

  typedef struct packed {
    op_t op;
    logic [4:0] step;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    begin
      case (i)
        5'd0: v = 32'd536870912;
        5'd1: v = 32'd316933406;
        5'd2: v = 32'd167458907;
        5'd3: v = 32'd85004756;
        5'd4: v = 32'd42667331;
        5'd5: v = 32'd21354465;
        5'd6: v = 32'd10679838;
        5'd7: v = 32'd5340245;
        5'd8: v = 32'd2670163;
        5'd9: v = 32'd1335087;
        5'd10: v = 32'd667544;
        5'd11: v = 32'd333772;
        5'd12: v = 32'd166886;
        5'd13: v = 32'd83443;
        5'd14: v = 32'd41722;
        5'd15: v = 32'd20861;
        5'd16: v = 32'd10430;
        5'd17: v = 32'd5215;
        5'd18: v = 32'd2608;
        5'd19: v = 32'd1304;
        5'd20: v = 32'd652;
        5'd21: v = 32'd326;
        5'd22: v = 32'd163;
        5'd23: v = 32'd81;
        default: v = 32'd0;
      endcase
      return v;
    end
  endfunction
endpackage
`default_nettype wire

### design/diff_drive_odometry_integrator_top.sv
// Differential-drive odometry: each accepted tick (left_speed, right_speed,
// elapsed_us) advances the pose and yields one result with pose and rates.
// From its transfer to its result a tick passes through rate forming,
// CORDIC_STEPS CORDIC micro-rotations (one per cycle, at most 24 steps), a
// projection multiply, a scaling multiply, the microsecond-to-second divide and
// a commit. The next tick is taken in the cycle after the commit. A result held
// by out_stall does not block the next tick; only that tick's commit waits for
// the transfer. Registers are written
// over APB at byte addresses 0 (wheel_speed_scale) and 4 (inverse_track_width).
`default_nettype none
module diff_drive_odometry_integrator_top #(
  parameter int CORDIC_STEPS = ddoi_pkg::CORDIC_STEPS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_stall,
  input wire logic signed [15:0] left_speed,
  input wire logic signed [15:0] right_speed,
  input wire logic [15:0] elapsed_us,
  output logic out_valid,
  input wire logic out_stall,
  output logic signed [31:0] pose_x,
  output logic signed [31:0] pose_y,
  output logic signed [15:0] pose_heading,
  output logic signed [23:0] forward_rate,
  output logic signed [23:0] turn_rate,
  input wire logic psel,
  input wire logic penable,
  input wire logic pwrite,
  input wire logic [2:0] paddr,
  input wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  ddoi_pkg::cmd_t cmd;
  ddoi_pkg::status_t status;
  logic [23:0] scale, inv_track;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= ddoi_pkg::SCALE_RESET;
      inv_track <= ddoi_pkg::INV_TRACK_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr == {ddoi_pkg::REG_SCALE, 2'b00})
        scale <= pwdata[23:0];
      else if (paddr == {ddoi_pkg::REG_INV_TRACK, 2'b00})
        inv_track <= pwdata[23:0];
    end
  end

  always_comb begin
    case (paddr)
      {ddoi_pkg::REG_SCALE, 2'b00}: prdata = {8'd0, scale};
      {ddoi_pkg::REG_INV_TRACK, 2'b00}: prdata = {8'd0, inv_track};
      default: prdata = '0;
    endcase
  end

  ddoi_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .status, .cmd
  );

  ddoi_datapath u_dp (
    .clk, .rst, .cmd, .status, .left_speed, .right_speed, .elapsed_us,
    .wheel_speed_scale(scale), .inverse_track_width(inv_track),
    .pose_x, .pose_y, .pose_heading, .forward_rate, .turn_rate
  );
endmodule
`default_nettype wire

### design/ddoi_ctrl.sv
`default_nettype none
module ddoi_ctrl #(
  parameter int CORDIC_STEPS = ddoi_pkg::CORDIC_STEPS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input wire logic out_stall,
  input wire ddoi_pkg::status_t status,
  output ddoi_pkg::cmd_t cmd
);
  localparam int STEPS = (CORDIC_STEPS > ddoi_pkg::CORDIC_TABLE_LEN) ?
                         ddoi_pkg::CORDIC_TABLE_LEN : CORDIC_STEPS;
  localparam logic [4:0] LAST = 5'(STEPS - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RATES = 7'b0000010,
    S_ROT = 7'b0000100,
    S_PROJ = 7'b0001000,
    S_SCALE = 7'b0010000,
    S_DIV = 7'b0100000,
    S_COMMIT = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [4:0] step;
  logic out_busy;

  // result register still waiting on its transfer
  assign out_busy = out_valid && out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op = ddoi_pkg::OP_IDLE;
    cmd.step = step;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = ddoi_pkg::OP_LOAD;
          state_next = S_RATES;
        end
      end
      S_RATES: begin
        cmd.op = ddoi_pkg::OP_RATES;
        state_next = S_ROT;
      end
      S_ROT: begin
        cmd.op = ddoi_pkg::OP_ROTATE;
        if (step == LAST) state_next = S_PROJ;
      end
      S_PROJ: begin
        cmd.op = ddoi_pkg::OP_PROJECT;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.op = ddoi_pkg::OP_SCALE;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = ddoi_pkg::OP_DIVIDE;
        if (status.div_done) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (!out_busy) begin
          cmd.op = ddoi_pkg::OP_COMMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_ROT) step <= step + 5'd1;
      else step <= '0;
      if (state == S_COMMIT && !out_busy) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

### design/ddoi_datapath.sv
`default_nettype none
module ddoi_datapath (
  input wire logic clk,
  input wire logic rst,
  input wire ddoi_pkg::cmd_t cmd,
  output ddoi_pkg::status_t status,
  input wire logic signed [15:0] left_speed,
  input wire logic signed [15:0] right_speed,
  input wire logic [15:0] elapsed_us,
  input wire logic [23:0] wheel_speed_scale,
  input wire logic [23:0] inverse_track_width,
  output logic signed [31:0] pose_x,
  output logic signed [31:0] pose_y,
  output logic signed [15:0] pose_heading,
  output logic signed [23:0] forward_rate,
  output logic signed [23:0] turn_rate
);
  localparam logic [20:0] RECIP = 21'd1099511;
  localparam logic [13:0] DIV_REST = 14'd15625;

  logic signed [41:0] lw, rw;
  logic [15:0] dt;
  logic signed [23:0] fwd, turn;
  logic signed [33:0] cx, cy, cz;
  logic flip;
  logic signed [47:0] vc, vs;
  logic signed [63:0] px, py;
  logic signed [63:0] hprod;
  logic [1:0] dcnt;
  logic [33:0] m_x, m_y;
  logic [20:0] qe_x, qe_y;
  logic [15:0] r_x, r_y;
  logic [20:0] q_x, q_y;
  logic neg_x, neg_y;
  logic signed [15:0] heading;

  logic signed [42:0] sum_lr, diff_rl;
  logic signed [33:0] sum_sh;
  logic signed [38:0] diff_sh;
  logic signed [63:0] turn_full;
  logic signed [31:0] a_ext;
  logic signed [33:0] xs, ys;
  logic [31:0] at;
  logic signed [15:0] dh;
  logic signed [33:0] acc_nx, acc_ny;
  logic [63:0] mag_x, mag_y;
  logic [44:0] prod_x, prod_y;
  logic [34:0] rq_x, rq_y;

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [1:0] fix_up(input logic [15:0] r);
    if (r >= 16'd46875) return 2'd3;
    if (r >= 16'd31250) return 2'd2;
    if (r >= 16'd15625) return 2'd1;
    return 2'd0;
  endfunction

  always_comb begin
    sum_lr = 43'(lw) + 43'(rw);
    diff_rl = 43'(rw) - 43'(lw);
    sum_sh = 34'(sum_lr >>> 9);
    diff_sh = 39'(diff_rl >>> 4);
    turn_full = 64'(diff_sh) * $signed({1'b0, inverse_track_width});
    a_ext = {heading, 16'd0};
    xs = cx >>> cmd.step;
    ys = cy >>> cmd.step;
    at = ddoi_pkg::atan_entry(cmd.step);
    dh = 16'((hprod + (64'sd1 <<< 39)) >>> 40);
    mag_x = px[63] ? 64'(-px) : 64'(px);
    mag_y = py[63] ? 64'(-py) : 64'(py);
    prod_x = 45'(m_x[33:10]) * 45'(RECIP);
    prod_y = 45'(m_y[33:10]) * 45'(RECIP);
    rq_x = 35'(qe_x) * 35'(DIV_REST);
    rq_y = 35'(qe_y) * 35'(DIV_REST);
    acc_nx = 34'(pose_x) + (neg_x ? -34'(q_x) : 34'(q_x));
    acc_ny = 34'(pose_y) + (neg_y ? -34'(q_y) : 34'(q_y));
  end

  assign status.div_done = (dcnt == 2'd3);
  assign pose_heading = heading;

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x <= '0;
      pose_y <= '0;
      heading <= '0;
      dcnt <= '0;
    end else begin
      case (cmd.op)
        ddoi_pkg::OP_LOAD: begin
          lw <= 42'(left_speed) * $signed({1'b0, wheel_speed_scale});
          rw <= -(42'(right_speed) * $signed({1'b0, wheel_speed_scale}));
          dt <= elapsed_us;
          flip <= a_ext[31] ^ a_ext[30];
          cz <= 34'(a_ext[31:30] == 2'b01 || a_ext[31:30] == 2'b10 ?
                    $signed(a_ext + 32'sh80000000) : a_ext);
          cx <= 34'(ddoi_pkg::CORDIC_GAIN);
          cy <= '0;
        end
        ddoi_pkg::OP_RATES: begin
          fwd <= sat24(64'(sum_sh));
          turn <= sat24(turn_full >>> 20);
        end
        ddoi_pkg::OP_ROTATE: begin
          if (!cz[33]) begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - $signed({2'b0, at});
          end else begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + $signed({2'b0, at});
          end
        end
        ddoi_pkg::OP_PROJECT: begin
          vc <= 48'((64'(fwd) * 64'(flip ? -cx : cx)) >>> 20);
          vs <= 48'((64'(fwd) * 64'(flip ? -cy : cy)) >>> 20);
          hprod <= 64'(turn) * $signed({1'b0, dt});
        end
        ddoi_pkg::OP_SCALE: begin
          px <= 64'(vc) * $signed({1'b0, dt});
          py <= 64'(vs) * $signed({1'b0, dt});
          hprod <= hprod * $signed({1'b0, ddoi_pkg::HEADING_COEF});
          dcnt <= '0;
        end
        ddoi_pkg::OP_DIVIDE: begin
          dcnt <= dcnt + 2'd1;
        end
        ddoi_pkg::OP_COMMIT: begin
          pose_x <= sat32(acc_nx);
          pose_y <= sat32(acc_ny);
          heading <= heading + dh;
          forward_rate <= fwd;
          turn_rate <= turn;
        end
        default: ;
      endcase
    end
  end

  // divide magnitudes by 2^16 * 15625: shift, reciprocal multiply, remainder fix-up
  always_ff @(posedge clk) begin
    if (cmd.op == ddoi_pkg::OP_DIVIDE) begin
      case (dcnt)
        2'd0: begin
          neg_x <= px[63];
          neg_y <= py[63];
          m_x <= 34'(mag_x >> 16);
          m_y <= 34'(mag_y >> 16);
        end
        2'd1: begin
          qe_x <= 21'(prod_x >> 24);
          qe_y <= 21'(prod_y >> 24);
        end
        2'd2: begin
          r_x <= 16'(35'(m_x) - rq_x);
          r_y <= 16'(35'(m_y) - rq_y);
        end
        default: begin
          q_x <= qe_x + 21'(fix_up(r_x));
          q_y <= qe_y + 21'(fix_up(r_y));
        end
      endcase
    end
  end
endmodule
`default_nettype wire
